// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define HSF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define HSF_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define HSF_ASSERT(lbl, clk, rst_n, prop)
`define HSF_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hdl/hsfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfcc_pkg
// Constants and types for the humidity sensor frame check and convert block.
// ----------------------------------------------------------------------------
package hsfcc_pkg;

    // CRC-8 over each 16-bit word, MSB first
    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;

    // frame layout
    localparam int          FRAME_LAST = 5;

    // conversion constants
    localparam logic [15:0] FULL_SCALE      = 16'hFFFF;
    localparam int          T_SCALE         = 175;
    localparam int          T_OFFSET        = 45;
    localparam int          H_SCALE         = 100;
    localparam int          MICRO_SCALE     = 1000000;
    localparam int          H_MICRO_MUL     = 15625;
    localparam int          H_MICRO_SHIFT   = 10;

    // serial divider: numerator width covers 1000000 * 65534
    localparam int          NUM_W     = 36;
    localparam int          DIV_CNT_W = $clog2(NUM_W);
    localparam int          HM_PROD_W = 30;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_CRC = 2'd1,
        STATUS_HUM_CRC  = 2'd2
    } status_t;

endpackage

// ===== hdl/humidity_sensor_frame_check_convert.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert
// Checks the two CRC-8 protected words of a six byte sensor frame and converts
// the last good temperature and humidity samples to whole and micro parts.
// ----------------------------------------------------------------------------
// Data bytes of a word are accepted and then take 8 CRC bit steps each (ST_CRC);
// CRC bytes are compared on acceptance. No byte is accepted while the block is busy
// with the bit-serial CRC, the one-bit-per-cycle divider (three 36 step divisions
// per frame) or a wait for a free output slot.
// Reset (aresetn low, synchronous): position, samples, order bit and the output
// valid are cleared; frame byte storage is not reset.
module humidity_sensor_frame_check_convert
    import hsfcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [8:0]  m_temp_whole,
    output logic [19:0]        m_temp_micro,
    output logic [6:0]         m_hum_whole,
    output logic [19:0]        m_hum_micro,
    output logic [15:0]        m_temp_raw,
    output logic [15:0]        m_hum_raw
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_DIV,
        ST_MUL_TM,
        ST_MUL_HM,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_T_WHOLE,
        OP_T_MICRO,
        OP_H_WHOLE
    } div_op_t;

    // control state
    state_t               state_reg, state_next;
    div_op_t              op_reg, op_next;
    logic [2:0]           pos_reg, pos_next;
    logic                 hum_first_reg, hum_first_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [15:0]          temp_sample_reg, temp_sample_next;
    logic [15:0]          hum_sample_reg, hum_sample_next;
    logic                 m_valid_reg, m_valid_next;

    // datapath
    logic [7:0]           crc_reg, crc_next;
    logic [7:0]           shift_reg, shift_next;
    logic [15:0]          word_a_reg, word_a_next;
    logic [15:0]          word_b_reg, word_b_next;
    logic                 ok_a_reg, ok_a_next;
    status_t              status_reg, status_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [15:0]          rem_reg, rem_next;
    logic [8:0]           tw_reg, tw_next;
    logic [19:0]          tm_reg, tm_next;
    logic [6:0]           hw_reg, hw_next;
    logic [19:0]          hm_reg, hm_next;

    // output registers
    logic [1:0]           m_status_reg, m_status_next;
    logic [8:0]           m_tw_reg, m_tw_next;
    logic [19:0]          m_tm_reg, m_tm_next;
    logic [6:0]           m_hw_reg, m_hw_next;
    logic [19:0]          m_hm_reg, m_hm_next;
    logic [15:0]          m_traw_reg, m_traw_next;
    logic [15:0]          m_hraw_reg, m_hraw_next;

    logic                 s_accept;
    logic                 crc_fb;
    logic [16:0]          rem_shift;
    logic                 div_ge;
    logic [16:0]          rem_sub;
    logic [NUM_W-1:0]     div_quot;
    logic [15:0]          div_rem;
    logic                 ok_b;
    logic                 temp_ok;
    logic                 hum_ok;
    logic [15:0]          temp_word;
    logic [15:0]          hum_word;
    logic [15:0]          temp_new;
    logic [HM_PROD_W-1:0] hm_prod;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // one CRC bit step, MSB first
    assign crc_fb = crc_reg[7] ^ shift_reg[7];

    // one restoring division step by the full scale value
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, FULL_SCALE});
    assign rem_sub   = rem_shift - {1'b0, FULL_SCALE};
    assign div_quot  = {num_reg[NUM_W-2:0], div_ge};
    assign div_rem   = div_ge ? rem_sub[15:0] : rem_shift[15:0];

    // word selection at the last frame byte
    assign ok_b      = (crc_reg == s_rx_byte);
    assign temp_ok   = hum_first_reg ? ok_b : ok_a_reg;
    assign hum_ok    = hum_first_reg ? ok_a_reg : ok_b;
    assign temp_word = hum_first_reg ? word_b_reg : word_a_reg;
    assign hum_word  = hum_first_reg ? word_a_reg : word_b_reg;
    assign temp_new  = (temp_ok && hum_ok) ? temp_word : temp_sample_reg;

    assign hm_prod = HM_PROD_W'(rem_reg) * HM_PROD_W'(H_MICRO_MUL);

    // next state and datapath
    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        pos_next         = pos_reg;
        hum_first_next   = hum_first_reg;
        bit_cnt_next     = bit_cnt_reg;
        div_cnt_next     = div_cnt_reg;
        temp_sample_next = temp_sample_reg;
        hum_sample_next  = hum_sample_reg;
        m_valid_next     = m_valid_reg;
        crc_next         = crc_reg;
        shift_next       = shift_reg;
        word_a_next      = word_a_reg;
        word_b_next      = word_b_reg;
        ok_a_next        = ok_a_reg;
        status_next      = status_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        tw_next          = tw_reg;
        tm_next          = tm_reg;
        hw_next          = hw_reg;
        hm_next          = hm_reg;
        m_status_next    = m_status_reg;
        m_tw_next        = m_tw_reg;
        m_tm_next        = m_tm_reg;
        m_hw_next        = m_hw_reg;
        m_hm_next        = m_hm_reg;
        m_traw_next      = m_traw_reg;
        m_hraw_next      = m_hraw_reg;

        if (cfg_wr_en) begin
            hum_first_next = cfg_wr_data;
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pos_next     = pos_reg + 3'd1;
                    shift_next   = s_rx_byte;
                    bit_cnt_next = 3'd7;
                    case (pos_reg)
                        3'd0: begin
                            crc_next          = CRC_INIT;
                            word_a_next[15:8] = s_rx_byte;
                            state_next        = ST_CRC;
                        end
                        3'd1: begin
                            word_a_next[7:0] = s_rx_byte;
                            state_next       = ST_CRC;
                        end
                        3'd2: begin
                            ok_a_next = (crc_reg == s_rx_byte);
                        end
                        3'd3: begin
                            crc_next          = CRC_INIT;
                            word_b_next[15:8] = s_rx_byte;
                            state_next        = ST_CRC;
                        end
                        3'd4: begin
                            word_b_next[7:0] = s_rx_byte;
                            state_next       = ST_CRC;
                        end
                        default: begin
                            // last byte: decide status, update samples, start
                            pos_next = 3'd0;
                            if (!temp_ok) begin
                                status_next = STATUS_TEMP_CRC;
                            end else if (!hum_ok) begin
                                status_next = STATUS_HUM_CRC;
                            end else begin
                                status_next      = STATUS_OK;
                                temp_sample_next = temp_word;
                                hum_sample_next  = hum_word;
                            end
                            num_next     = NUM_W'(temp_new) * NUM_W'(T_SCALE);
                            rem_next     = 16'd0;
                            div_cnt_next = DIV_CNT_W'(NUM_W - 1);
                            op_next      = OP_T_WHOLE;
                            state_next   = ST_DIV;
                        end
                    endcase
                end
            end

            ST_CRC: begin
                crc_next     = {crc_reg[6:0], 1'b0} ^ (crc_fb ? CRC_POLY : 8'h00);
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 3'd1;
                if (bit_cnt_reg == 3'd0) begin
                    state_next = ST_IDLE;
                end
            end

            ST_DIV: begin
                num_next     = div_quot;
                rem_next     = div_rem;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0) begin
                    unique case (op_reg)
                        OP_T_WHOLE: begin
                            tw_next    = 9'(div_quot[7:0]) - 9'(T_OFFSET);
                            state_next = ST_MUL_TM;
                        end
                        OP_T_MICRO: begin
                            tm_next      = div_quot[19:0];
                            num_next     = NUM_W'(hum_sample_reg) * NUM_W'(H_SCALE);
                            rem_next     = 16'd0;
                            div_cnt_next = DIV_CNT_W'(NUM_W - 1);
                            op_next      = OP_H_WHOLE;
                        end
                        OP_H_WHOLE: begin
                            hw_next    = div_quot[6:0];
                            state_next = ST_MUL_HM;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_MUL_TM: begin
                num_next     = NUM_W'(rem_reg) * NUM_W'(MICRO_SCALE);
                rem_next     = 16'd0;
                div_cnt_next = DIV_CNT_W'(NUM_W - 1);
                op_next      = OP_T_MICRO;
                state_next   = ST_DIV;
            end

            ST_MUL_HM: begin
                hm_next    = hm_prod[HM_PROD_W-1:H_MICRO_SHIFT];
                state_next = ST_OUT;
            end

            ST_OUT: begin
                // wait for a free output slot
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_tw_next     = tw_reg;
                    m_tm_next     = tm_reg;
                    m_hw_next     = hw_reg;
                    m_hm_next     = hm_reg;
                    m_traw_next   = temp_sample_reg;
                    m_hraw_next   = hum_sample_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_T_WHOLE;
            pos_reg         <= 3'd0;
            hum_first_reg   <= 1'b0;
            bit_cnt_reg     <= 3'd0;
            div_cnt_reg     <= '0;
            temp_sample_reg <= 16'd0;
            hum_sample_reg  <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            pos_reg         <= pos_next;
            hum_first_reg   <= hum_first_next;
            bit_cnt_reg     <= bit_cnt_next;
            div_cnt_reg     <= div_cnt_next;
            temp_sample_reg <= temp_sample_next;
            hum_sample_reg  <= hum_sample_next;
            m_valid_reg     <= m_valid_next;
        end
        crc_reg      <= crc_next;
        shift_reg    <= shift_next;
        word_a_reg   <= word_a_next;
        word_b_reg   <= word_b_next;
        ok_a_reg     <= ok_a_next;
        status_reg   <= status_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        tw_reg       <= tw_next;
        tm_reg       <= tm_next;
        hw_reg       <= hw_next;
        hm_reg       <= hm_next;
        m_status_reg <= m_status_next;
        m_tw_reg     <= m_tw_next;
        m_tm_reg     <= m_tm_next;
        m_hw_reg     <= m_hw_next;
        m_hm_reg     <= m_hm_next;
        m_traw_reg   <= m_traw_next;
        m_hraw_reg   <= m_hraw_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_temp_whole = m_tw_reg;
    assign m_temp_micro = m_tm_reg;
    assign m_hum_whole  = m_hw_reg;
    assign m_hum_micro  = m_hm_reg;
    assign m_temp_raw   = m_traw_reg;
    assign m_hum_raw    = m_hraw_reg;

    // checks
    `HSF_NEVER(a_pos_range, aclk, aresetn, pos_reg > 3'(FRAME_LAST))
    `HSF_ASSERT(a_samples_hold, aclk, aresetn, (!(s_accept && pos_reg == 3'(FRAME_LAST))) |=> ($stable(temp_sample_reg) && $stable(hum_sample_reg)))
    `HSF_ASSERT(a_result_source, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
    `HSF_ASSERT(a_no_result_overwrite, aclk, aresetn, (m_valid_reg && !m_ready) |=> ($stable(m_status_reg) && $stable(m_traw_reg) && $stable(m_hraw_reg)))

endmodule

// ===== dv/tb_humidity_sensor_frame_check_convert.sv =====
// ----------------------------------------------------------------------------
// tb_humidity_sensor_frame_check_convert
// Self-checking bench for the sensor frame check and convert block. A short
// table of frames with hand-written results comes first. Phases of random
// frames follow: mostly CRC-clean frames with random words, plus bad CRCs and
// raw noise. A local model of the block predicts the random frames' results, and both
// channels stall at random.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_frame_check_convert
    import hsfcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;     // idle time once all results are drained
    localparam int HOLD_CYCLES   = 3000;    // long result back-pressure stretch
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_FRAMES  = 37;
    localparam int IDLE_PCT      = 23;

    // one result transaction
    typedef struct packed {
        status_t            status;
        logic signed [8:0]  temp_whole;
        logic [19:0]        temp_micro;
        logic [6:0]         hum_whole;
        logic [19:0]        hum_micro;
        logic [15:0]        temp_raw;
        logic [15:0]        hum_raw;
    } reading_t;

    // directed frame: order before the frame, order at byte six, words, CRC faults
    typedef struct packed {
        bit          order_start;
        bit          order_end;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        bit          temp_crc_bad;
        bit          hum_crc_bad;
        reading_t    want;
    } frame_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]         m_status;
    logic signed [8:0]  m_temp_whole;
    logic [19:0]        m_temp_micro;
    logic [6:0]         m_hum_whole;
    logic [19:0]        m_hum_micro;
    logic [15:0]        m_temp_raw;
    logic [15:0]        m_hum_raw;

    // frame model state
    logic [2:0]  frame_pos      = 3'd0;
    logic [7:0]  frame_buf [5]  = '{default: 8'h00};
    logic [15:0] good_temp      = 16'h0000;
    logic [15:0] good_hum       = 16'h0000;
    bit          hum_first      = 1'b0;

    reading_t    expected_readings [$];
    int          mismatches     = 0;
    int          cycle_count    = 0;
    bit          idle_on        = 1'b1;
    bit          hold_pending   = 1'b0;

    // after reset, extremes of both words, each CRC fault, order switched mid-frame
    frame_row_t directed_frames [5] = '{
        '{1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0,
          '{STATUS_TEMP_CRC, -9'sd45, 20'd0, 7'd0, 20'd0, 16'h0000, 16'h0000}},
        '{1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0,
          '{STATUS_OK, 9'sd130, 20'd0, 7'd100, 20'd0, 16'hFFFF, 16'hFFFF}},
        '{1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1,
          '{STATUS_TEMP_CRC, 9'sd130, 20'd0, 7'd100, 20'd0, 16'hFFFF, 16'hFFFF}},
        '{1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1,
          '{STATUS_HUM_CRC, 9'sd130, 20'd0, 7'd100, 20'd0, 16'hFFFF, 16'hFFFF}},
        '{1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0,
          '{STATUS_OK, -9'sd45, 20'd0, 7'd0, 20'd0, 16'h0000, 16'h0000}}
    };

    humidity_sensor_frame_check_convert u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_temp_whole (m_temp_whole),
        .m_temp_micro (m_temp_micro),
        .m_hum_whole  (m_hum_whole),
        .m_hum_micro  (m_hum_micro),
        .m_temp_raw   (m_temp_raw),
        .m_hum_raw    (m_hum_raw)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_humidity_sensor_frame_check_convert: FAIL");
            $finish;
        end
    end

    // CRC-8, poly 0x31, MSB first, over one 16-bit word
    function automatic logic [7:0] word_crc(input logic [15:0] word);
        logic [7:0] c;
        c = CRC_INIT;
        for (int k = 15; k >= 0; k--) begin
            if (c[7] ^ word[k])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // absorb one frame byte; on byte six produce the expected reading
    function automatic bit absorb_byte(input logic [7:0] b, output reading_t r);
        logic [7:0]      f [6];
        int              t_off;
        int              h_off;
        logic [15:0]     tw;
        logic [15:0]     hw;
        longint unsigned ts;
        longint unsigned hs;
        r = '0;
        if (frame_pos < 3'(FRAME_LAST)) begin
            frame_buf[frame_pos] = b;
            frame_pos = frame_pos + 3'd1;
            return 1'b0;
        end
        frame_pos = 3'd0;
        for (int i = 0; i < 5; i++) f[i] = frame_buf[i];
        f[5] = b;
        t_off = hum_first ? 3 : 0;
        h_off = 3 - t_off;
        tw = {f[t_off], f[t_off + 1]};
        hw = {f[h_off], f[h_off + 1]};
        // temperature word wins when both CRCs are bad
        if (word_crc(tw) != f[t_off + 2]) begin
            r.status = STATUS_TEMP_CRC;
        end else if (word_crc(hw) != f[h_off + 2]) begin
            r.status = STATUS_HUM_CRC;
        end else begin
            r.status  = STATUS_OK;
            good_temp = tw;
            good_hum  = hw;
        end
        ts = longint'(T_SCALE) * good_temp;
        hs = longint'(H_SCALE) * good_hum;
        r.temp_whole = 9'(longint'(ts / FULL_SCALE) - T_OFFSET);
        r.temp_micro = 20'((longint'(MICRO_SCALE) * (ts % FULL_SCALE)) / FULL_SCALE);
        r.hum_whole  = 7'(hs / FULL_SCALE);
        r.hum_micro  = 20'(((hs % FULL_SCALE) * H_MICRO_MUL) >> H_MICRO_SHIFT);
        r.temp_raw   = good_temp;
        r.hum_raw    = good_hum;
        return 1'b1;
    endfunction

    // lay out six frame bytes; a nonzero flip corrupts that word's CRC
    function automatic logic [5:0][7:0] pack_frame(input bit order, input logic [15:0] tw,
                                                   input logic [15:0] hw,
                                                   input logic [7:0] tflip,
                                                   input logic [7:0] hflip);
        logic [2:0][7:0] t_part;
        logic [2:0][7:0] h_part;
        logic [5:0][7:0] fb;
        t_part = {word_crc(tw) ^ tflip, tw[7:0], tw[15:8]};
        h_part = {word_crc(hw) ^ hflip, hw[7:0], hw[15:8]};
        fb = order ? {t_part, h_part} : {h_part, t_part};
        return fb;
    endfunction

    // mostly random words, now and then an edge value
    function automatic logic [15:0] pick_word();
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
        if ($urandom_range(99) < 15)
            return edges[$urandom_range(5)];
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // compare one accepted result with the oldest expectation
    task automatic check_reading();
        reading_t got;
        reading_t want;
        got = '{status_t'(m_status), m_temp_whole, m_temp_micro, m_hum_whole,
                m_hum_micro, m_temp_raw, m_hum_raw};
        if (expected_readings.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
            return;
        end
        want = expected_readings.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.temp_whole !== want.temp_whole)
            report_mismatch($sformatf("temp_whole %0d, want %0d",
                                      got.temp_whole, want.temp_whole));
        if (got.temp_micro !== want.temp_micro)
            report_mismatch($sformatf("temp_micro %0d, want %0d",
                                      got.temp_micro, want.temp_micro));
        if (got.hum_whole !== want.hum_whole)
            report_mismatch($sformatf("hum_whole %0d, want %0d",
                                      got.hum_whole, want.hum_whole));
        if (got.hum_micro !== want.hum_micro)
            report_mismatch($sformatf("hum_micro %0d, want %0d",
                                      got.hum_micro, want.hum_micro));
        if (got.temp_raw !== want.temp_raw)
            report_mismatch($sformatf("temp_raw %h, want %h", got.temp_raw, want.temp_raw));
        if (got.hum_raw !== want.hum_raw)
            report_mismatch($sformatf("hum_raw %h, want %h", got.hum_raw, want.hum_raw));
    endtask

    // offer one byte, hold it until accepted, then predict
    task automatic send_byte(input logic [7:0] b, input bit use_want, input reading_t want);
        reading_t r;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while (idle_on && $urandom_range(99) < IDLE_PCT);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (absorb_byte(b, r))
            expected_readings.push_back(use_want ? want : r);
    endtask

    // drain all results, then give the block time to finish the last byte
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_order(input bit value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        hum_first = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // send one frame; a new order is written after byte three if it differs
    task automatic run_frame(input bit order_end, input logic [5:0][7:0] fb,
                             input bit use_want, input reading_t want);
        for (int i = 0; i < 6; i++) begin
            if (i == 3 && order_end != hum_first) begin
                settle();
                write_order(order_end);
            end
            send_byte(fb[i], use_want && i == 5, want);
        end
    endtask

    // result side: random ready, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                check_reading();
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // stimulus
    initial begin
        int              kind;
        bit              order_end;
        logic [15:0]     tw;
        logic [15:0]     hw;
        logic [7:0]      tflip;
        logic [7:0]      hflip;
        logic [5:0][7:0] fb;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_order(1'b0);

        // directed table
        foreach (directed_frames[i]) begin
            if (directed_frames[i].order_start != hum_first) begin
                settle();
                write_order(directed_frames[i].order_start);
            end
            fb = pack_frame(directed_frames[i].order_end, directed_frames[i].temp_word,
                            directed_frames[i].hum_word,
                            directed_frames[i].temp_crc_bad ? 8'h5A : 8'h00,
                            directed_frames[i].hum_crc_bad ? 8'h5A : 8'h00);
            run_frame(directed_frames[i].order_end, fb, 1'b1, directed_frames[i].want);
        end

        // random phases: phase 2 never idles, phase 4 holds the result side off
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            write_order(ph < 4 ? bit'(ph % 2) : bit'($urandom_range(1)));
            idle_on = (ph != 2);
            if (ph == 4)
                hold_pending = 1'b1;
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                kind      = $urandom_range(99);
                order_end = ($urandom_range(99) < 6) ? !hum_first : hum_first;
                tw        = pick_word();
                hw        = pick_word();
                tflip     = (kind >= 70 && kind < 78) || (kind >= 86 && kind < 90)
                            ? 8'($urandom_range(1, 255)) : 8'h00;
                hflip     = (kind >= 78 && kind < 90) ? 8'($urandom_range(1, 255)) : 8'h00;
                if (kind >= 90) begin
                    // noise: six random bytes
                    for (int i = 0; i < 6; i++) fb[i] = 8'($urandom_range(255));
                end else begin
                    fb = pack_frame(order_end, tw, hw, tflip, hflip);
                end
                run_frame(order_end, fb, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("tb_humidity_sensor_frame_check_convert: PASS");
        else
            $display("tb_humidity_sensor_frame_check_convert: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hsfcc_pkg.sv
hdl/humidity_sensor_frame_check_convert.sv
dv/tb_humidity_sensor_frame_check_convert.sv
